FILE: sv/ptw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared types, codes and a helper function of the x86 page table walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

    localparam int PHYS_ADDR_BITS_DEF = 52;
    localparam int ADDR_W             = 52;
    localparam int VA_W               = 64;
    localparam int CFG_DATA_W         = 64;
    localparam int CFG_ADDR_W         = 5;

    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_32    = 2'd1,
        MODE_PAE   = 2'd2,
        MODE_LONG4 = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REG_PAGING = 2'd0,
        REG_PAE    = 2'd1,
        REG_LME    = 2'd2,
        REG_DIR    = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        ACT_TRANSLATE = 1'b0,
        ACT_ENTRY     = 1'b1
    } action_t;

    typedef enum logic {
        KIND_READ = 1'b0,
        KIND_DONE = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK          = 2'd0,
        STAT_NOT_PRESENT = 2'd1,
        STAT_READ_FAILED = 2'd2,
        STAT_UNEXPECTED  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PS_4K = 2'd0,
        PS_2M = 2'd1,
        PS_4M = 2'd2,
        PS_1G = 2'd3
    } page_size_t;

    typedef struct packed {
        kind_t              kind;
        logic [ADDR_W-1:0]  read_address;
        logic [3:0]         read_bytes;
        logic [ADDR_W-1:0]  physical_address;
        status_t            status;
        logic [1:0]         fault_level;
        page_size_t         page_size;
    } result_t;

    localparam logic [ADDR_W-1:0] BASE_MASK_32   = 52'h00000fffff000;
    localparam logic [ADDR_W-1:0] BASE_MASK_PAE  = 52'h00000ffffffe0;
    localparam logic [ADDR_W-1:0] BASE_MASK_LONG = 52'hffffffffff000;

    // Byte offset of the entry in the table that lies d levels above the page.
    function automatic logic [11:0] entry_offset(mode_t mode, logic [VA_W-1:0] va,
                                                 logic [1:0] d);
        logic [11:0] off;
        off = '0;
        if (mode == MODE_32) begin
            case (d)
                2'd0:    off = {va[21:12], 2'b00};
                2'd1:    off = {va[31:22], 2'b00};
                default: off = '0;
            endcase
        end
        else begin
            case (d)
                2'd0:    off = {va[20:12], 3'b000};
                2'd1:    off = {va[29:21], 3'b000};
                2'd2:    off = {va[38:30], 3'b000};
                default: off = {va[47:39], 3'b000};
            endcase
        end
        return off;
    endfunction

endpackage

FILE: sv/x86_page_table_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86_page_table_walker
// Steps an x86 page table walk by one level per request, in 32-bit, PAE or
// 4-level mode, or passes addresses through when paging is off.
// ----------------------------------------------------------------------------
//  Channel | Handshake                        | Payload
//  --------+----------------------------------+---------------------------------
//  in      | in_valid / in_stall              | action, virtual_address,
//          |                                  | table_entry, read_failed
//  out     | out_valid / out_stall            | result_kind, read_address,
//          |                                  | read_bytes, physical_address,
//          |                                  | status, fault_level, page_size
//  cfg     | psel, penable, pwrite, pready    | paddr, pwdata, prdata
//
// One request is accepted per cycle unless in_stall holds the input channel.
// The input register and the result register each hold one request; the
// walk state is updated when a request moves from one to the other.
// A stalled output holds the result register, and the input register then
// stalls the input channel. Reset idles the walk and clears the control state.
// ----------------------------------------------------------------------------
module x86_page_table_walker
#(
    parameter int PHYS_ADDR_BITS = ptw_pkg::PHYS_ADDR_BITS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ptw_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [ptw_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [ptw_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready,

    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               action,
    input  logic [ptw_pkg::VA_W-1:0]           virtual_address,
    input  logic [ptw_pkg::VA_W-1:0]           table_entry,
    input  logic                               read_failed,

    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               result_kind,
    output logic [ptw_pkg::ADDR_W-1:0]         read_address,
    output logic [3:0]                         read_bytes,
    output logic [ptw_pkg::ADDR_W-1:0]         physical_address,
    output logic [1:0]                         status,
    output logic [1:0]                         fault_level,
    output logic [1:0]                         page_size
);

    import ptw_pkg::*;

    localparam logic [63:0]       PMASK64 = (64'd1 << PHYS_ADDR_BITS) - 64'd1;
    localparam logic [ADDR_W-1:0] PMASK   = PMASK64[ADDR_W-1:0];

    logic               paging_reg;
    logic               pae_reg;
    logic               lme_reg;
    logic [ADDR_W-1:0]  dir_reg;
    logic               cfg_write;
    cfg_reg_t           cfg_sel;

    logic               in_valid_reg;
    logic               action_reg;
    logic [VA_W-1:0]    va_reg;
    logic [VA_W-1:0]    entry_reg;
    logic               failed_reg;

    logic               busy_reg;
    logic               busy_next;
    logic [1:0]         level_reg;
    logic [1:0]         level_next;
    logic [VA_W-1:0]    saved_reg;
    logic [VA_W-1:0]    saved_next;

    logic               out_valid_reg;
    result_t            result_reg;
    result_t            result_next;

    logic               load_out;
    logic               advance;

    mode_t              mode;
    logic [1:0]         last_d;
    logic [1:0]         lvl;
    logic [1:0]         d;
    logic [3:0]         esize;
    logic [VA_W-1:0]    va_req;
    logic [VA_W-1:0]    va_walk;
    logic [VA_W-1:0]    entry;
    logic [ADDR_W-1:0]  base;
    logic [ADDR_W-1:0]  frame;
    logic [39:0]        big4m;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = cfg_reg_t'(paddr[4:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            paging_reg <= 1'b0;
            pae_reg    <= 1'b0;
            lme_reg    <= 1'b0;
            dir_reg    <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                REG_PAGING: paging_reg <= pwdata[0];
                REG_PAE:    pae_reg    <= pwdata[0];
                REG_LME:    lme_reg    <= pwdata[0];
                REG_DIR:    dir_reg    <= pwdata[ADDR_W-1:0];
                default:    dir_reg    <= dir_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_PAGING: prdata = {{(CFG_DATA_W-1){1'b0}}, paging_reg};
            REG_PAE:    prdata = {{(CFG_DATA_W-1){1'b0}}, pae_reg};
            REG_LME:    prdata = {{(CFG_DATA_W-1){1'b0}}, lme_reg};
            REG_DIR:    prdata = {{(CFG_DATA_W-ADDR_W){1'b0}}, dir_reg};
            default:    prdata = '0;
        endcase
    end

    // Handshake between the input register and the result register.
    assign load_out = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && load_out;
    assign in_stall = in_valid_reg && !load_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            action_reg <= action;
            va_reg     <= virtual_address;
            entry_reg  <= table_entry;
            failed_reg <= read_failed;
        end
    end

    // One level of the walk.
    always_comb
    begin
        if (!paging_reg)
            mode = MODE_NONE;
        else if (!pae_reg)
            mode = MODE_32;
        else if (lme_reg)
            mode = MODE_LONG4;
        else
            mode = MODE_PAE;

        last_d = (mode == MODE_32) ? 2'd1 : (mode == MODE_PAE) ? 2'd2 : 2'd3;
        lvl    = (level_reg > last_d) ? last_d : level_reg;
        d      = last_d - lvl;
        esize  = (mode == MODE_32) ? 4'd4 : 4'd8;

        va_req  = (mode == MODE_LONG4) ? va_reg : {32'd0, va_reg[31:0]};
        va_walk = (mode == MODE_LONG4) ? saved_reg : {32'd0, saved_reg[31:0]};
        entry   = (mode == MODE_32) ? {32'd0, entry_reg[31:0]} : entry_reg;

        case (mode)
            MODE_32:  base = dir_reg & BASE_MASK_32;
            MODE_PAE: base = dir_reg & BASE_MASK_PAE;
            default:  base = dir_reg & BASE_MASK_LONG;
        endcase

        if (mode == MODE_32)
            frame = {20'd0, entry[31:12], 12'd0};
        else
            frame = {entry[ADDR_W-1:12], 12'd0} & PMASK;

        big4m = {entry[20:13], entry[31:22], va_walk[21:0]};

        busy_next  = busy_reg;
        level_next = level_reg;
        saved_next = saved_reg;

        result_next.kind             = KIND_DONE;
        result_next.read_address     = '0;
        result_next.read_bytes       = esize;
        result_next.physical_address = '0;
        result_next.status           = STAT_OK;
        result_next.fault_level      = lvl;
        result_next.page_size        = PS_4K;

        if (action_t'(action_reg) == ACT_TRANSLATE)
        begin
            saved_next                = va_reg;
            level_next                = 2'd0;
            result_next.fault_level   = 2'd0;
            if (mode == MODE_NONE)
            begin
                busy_next                    = 1'b0;
                result_next.physical_address = va_reg[ADDR_W-1:0] & PMASK;
            end
            else
            begin
                busy_next                = 1'b1;
                result_next.kind         = KIND_READ;
                result_next.read_address =
                    ((base & PMASK) + {40'd0, entry_offset(mode, va_req, last_d)}) & PMASK;
            end
        end
        else if (!busy_reg || mode == MODE_NONE)
        begin
            busy_next               = 1'b0;
            result_next.status      = STAT_UNEXPECTED;
            result_next.fault_level = level_reg;
        end
        else if (failed_reg)
        begin
            busy_next          = 1'b0;
            result_next.status = STAT_READ_FAILED;
        end
        else if (!entry[0])
        begin
            busy_next          = 1'b0;
            result_next.status = STAT_NOT_PRESENT;
        end
        else if (d == 2'd0)
        begin
            busy_next                    = 1'b0;
            result_next.physical_address = {frame[ADDR_W-1:12], va_walk[11:0]} & PMASK;
        end
        else if (d == 2'd1 && entry[7])
        begin
            busy_next = 1'b0;
            if (mode == MODE_32)
            begin
                result_next.physical_address = {12'd0, big4m} & PMASK;
                result_next.page_size        = PS_4M;
            end
            else
            begin
                result_next.physical_address = {frame[ADDR_W-1:21], va_walk[20:0]} & PMASK;
                result_next.page_size        = PS_2M;
            end
        end
        else if (d == 2'd2 && mode == MODE_LONG4 && entry[7])
        begin
            busy_next                    = 1'b0;
            result_next.physical_address = {frame[ADDR_W-1:30], va_walk[29:0]} & PMASK;
            result_next.page_size        = PS_1G;
        end
        else
        begin
            level_next               = lvl + 2'd1;
            result_next.kind         = KIND_READ;
            result_next.fault_level  = lvl + 2'd1;
            result_next.read_address =
                (frame + {40'd0, entry_offset(mode, va_walk, d - 2'd1)}) & PMASK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            level_reg     <= 2'd0;
            saved_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                busy_reg  <= busy_next;
                level_reg <= level_next;
                saved_reg <= saved_next;
            end
            if (load_out)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign result_kind      = result_reg.kind;
    assign read_address     = result_reg.read_address;
    assign read_bytes       = result_reg.read_bytes;
    assign physical_address = result_reg.physical_address;
    assign status           = result_reg.status;
    assign fault_level      = result_reg.fault_level;
    assign page_size        = result_reg.page_size;

endmodule

FILE: bench/x86_page_table_walker_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86_page_table_walker_test
// Self-checking bench for the page table walker. A short table of directed
// requests covers identity mode, the extremes of every field, each page size,
// faults, stray entries and mode changes in the middle of a walk. Random
// phases follow, each under new register values, with walks of random entry
// content and random idling on both channels. Each result is checked against
// a directed row's known value or a cycle-free walk model beside the stimulus.
// ----------------------------------------------------------------------------
module x86_page_table_walker_test;
    import ptw_pkg::*;

    localparam int                 PHASES         = 12;
    localparam int                 PHASE_REQUESTS = 86;
    localparam int                 WATCHDOG_LIMIT = 2000;
    localparam int                 DRAIN_CYCLES   = 4;
    localparam logic [51:0]        ONES52         = {52{1'b1}};
    localparam logic [63:0]        ONES64         = {64{1'b1}};
    localparam logic [51:0]        DIR_MASK_32    = 52'h00000fffff000;
    localparam logic [51:0]        DIR_MASK_PAE   = 52'h00000ffffffe0;
    localparam logic [51:0]        DIR_MASK_LONG  = 52'hffffffffff000;
    localparam result_t            NO_CHECK       = '0;

    typedef struct packed {
        mode_t       mode;
        logic [51:0] dir;
        action_t     act;
        logic [63:0] va;
        logic [63:0] entry;
        logic        rf;
        logic        typed;
        result_t     known;
    } directed_row_t;

    localparam int DIRECTED_COUNT = 26;
    localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{MODE_NONE, 52'h0, ACT_ENTRY, 64'h0, 64'h0, 1'b0, 1'b1,
          '{KIND_DONE, 52'h0, 4'd8, 52'h0, STAT_UNEXPECTED, 2'd0, PS_4K}},
        '{MODE_NONE, 52'h0, ACT_TRANSLATE, ONES64, 64'h0, 1'b0, 1'b1,
          '{KIND_DONE, 52'h0, 4'd8, ONES52, STAT_OK, 2'd0, PS_4K}},
        '{MODE_NONE, 52'h0, ACT_TRANSLATE, 64'h0, 64'h0, 1'b0, 1'b1,
          '{KIND_DONE, 52'h0, 4'd8, 52'h0, STAT_OK, 2'd0, PS_4K}},
        '{MODE_32, ONES52, ACT_TRANSLATE, ONES64, 64'h0, 1'b0, 1'b1,
          '{KIND_READ, 52'hfffffffc, 4'd4, 52'h0, STAT_OK, 2'd0, PS_4K}},
        '{MODE_32, ONES52, ACT_ENTRY, 64'h0, ONES64, 1'b0, 1'b1,
          '{KIND_DONE, 52'h0, 4'd4, 52'h000ffffffffff, STAT_OK, 2'd0, PS_4M}},
        '{MODE_32, ONES52, ACT_TRANSLATE, 64'h0, 64'h0, 1'b0, 1'b0, NO_CHECK},
        '{MODE_32, ONES52, ACT_ENTRY, 64'h0, 64'h1, 1'b0, 1'b0, NO_CHECK},
        '{MODE_32, ONES52, ACT_ENTRY, 64'h0, ONES64, 1'b1, 1'b1,
          '{KIND_DONE, 52'h0, 4'd4, 52'h0, STAT_READ_FAILED, 2'd1, PS_4K}},
        '{MODE_32, ONES52, ACT_ENTRY, 64'h0, 64'h1, 1'b0, 1'b1,
          '{KIND_DONE, 52'h0, 4'd4, 52'h0, STAT_UNEXPECTED, 2'd1, PS_4K}},
        '{MODE_32, 52'h0, ACT_TRANSLATE, 64'h12345678, 64'h0, 1'b0, 1'b0, NO_CHECK},
        '{MODE_32, 52'h0, ACT_TRANSLATE, 64'hffffffff00000000, 64'h0, 1'b0, 1'b0,
          NO_CHECK},
        '{MODE_32, 52'h0, ACT_ENTRY, 64'h0, 64'hfffffffffffffffe, 1'b0, 1'b1,
          '{KIND_DONE, 52'h0, 4'd4, 52'h0, STAT_NOT_PRESENT, 2'd0, PS_4K}},
        '{MODE_PAE, ONES52, ACT_TRANSLATE, ONES64, 64'h0, 1'b0, 1'b1,
          '{KIND_READ, 52'hfffffff8, 4'd8, 52'h0, STAT_OK, 2'd0, PS_4K}},
        '{MODE_PAE, ONES52, ACT_ENTRY, 64'h0, ONES64, 1'b0, 1'b0, NO_CHECK},
        '{MODE_PAE, ONES52, ACT_ENTRY, 64'h0, 64'h8000000000000081, 1'b0, 1'b0,
          NO_CHECK},
        '{MODE_LONG4, ONES52, ACT_TRANSLATE, ONES64, 64'h0, 1'b0, 1'b0, NO_CHECK},
        '{MODE_LONG4, ONES52, ACT_ENTRY, 64'h0, 64'h000ffffffffff003, 1'b0, 1'b0,
          NO_CHECK},
        '{MODE_LONG4, ONES52, ACT_ENTRY, 64'h0, 64'h7ff00000c0000081, 1'b0, 1'b0,
          NO_CHECK},
        '{MODE_LONG4, 52'h0, ACT_TRANSLATE, 64'h00007ffffffff123, 64'h0, 1'b0, 1'b0,
          NO_CHECK},
        '{MODE_LONG4, 52'h0, ACT_ENTRY, 64'h0, 64'h1007, 1'b0, 1'b0, NO_CHECK},
        '{MODE_LONG4, 52'h0, ACT_ENTRY, 64'h0, 64'h2003, 1'b0, 1'b0, NO_CHECK},
        '{MODE_LONG4, 52'h0, ACT_ENTRY, 64'h0, 64'h3001, 1'b0, 1'b0, NO_CHECK},
        '{MODE_32, 52'h0, ACT_ENTRY, 64'h0, 64'h0000000000401001, 1'b0, 1'b0,
          NO_CHECK},
        '{MODE_LONG4, 52'h0, ACT_TRANSLATE, 64'hffff800000000000, 64'h0, 1'b0, 1'b0,
          NO_CHECK},
        '{MODE_LONG4, 52'h0, ACT_ENTRY, 64'h0, 64'h5001, 1'b0, 1'b0, NO_CHECK},
        '{MODE_NONE, 52'h0, ACT_ENTRY, 64'h0, 64'h1, 1'b0, 1'b1,
          '{KIND_DONE, 52'h0, 4'd8, 52'h0, STAT_UNEXPECTED, 2'd1, PS_4K}}
    };

    logic                  clk             = 1'b0;
    logic                  rst_n           = 1'b0;
    logic                  psel            = 1'b0;
    logic                  penable         = 1'b0;
    logic                  pwrite          = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr           = '0;
    logic [CFG_DATA_W-1:0] pwdata          = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid        = 1'b0;
    logic                  in_stall;
    logic                  action          = 1'b0;
    logic [VA_W-1:0]       virtual_address = '0;
    logic [VA_W-1:0]       table_entry     = '0;
    logic                  read_failed     = 1'b0;
    logic                  out_valid;
    logic                  out_stall       = 1'b0;
    logic                  result_kind;
    logic [ADDR_W-1:0]     read_address;
    logic [3:0]            read_bytes;
    logic [ADDR_W-1:0]     physical_address;
    logic [1:0]            status;
    logic [1:0]            fault_level;
    logic [1:0]            page_size;

    logic                  cfg_paging      = 1'b0;
    logic                  cfg_pae         = 1'b0;
    logic                  cfg_lme         = 1'b0;
    logic [51:0]           cfg_dir         = '0;
    logic                  tr_busy         = 1'b0;
    logic [1:0]            tr_level        = '0;
    logic [63:0]           tr_va           = '0;

    result_t               pending_results[$];
    int                    mismatches      = 0;
    int                    idle_cycles     = 0;
    int                    stall_left      = 0;
    logic                  quiet           = 1'b0;
    int                    requests_sent   = 0;
    int                    settings_used   = 0;
    int                    reads_seen      = 0;
    int                    pages_seen      = 0;
    int                    faults_seen     = 0;

    x86_page_table_walker dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .action           (action),
        .virtual_address  (virtual_address),
        .table_entry      (table_entry),
        .read_failed      (read_failed),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .result_kind      (result_kind),
        .read_address     (read_address),
        .read_bytes       (read_bytes),
        .physical_address (physical_address),
        .status           (status),
        .fault_level      (fault_level),
        .page_size        (page_size)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int idle_length();
        int r;
        r = $urandom_range(99);
        if (quiet || r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic logic [51:0] table_index(mode_t m, logic [63:0] v, int d);
        logic [63:0] t;
        if (m == MODE_32)
        begin
            t = (v >> (12 + 10 * d)) & 64'h3ff;
            return t[51:0] << 2;
        end
        t = (v >> (12 + 9 * d)) & 64'h1ff;
        return t[51:0] << 3;
    endfunction

    // Advances the walk state by one request and returns the result it causes.
    function automatic result_t walk_step(action_t act, logic [63:0] va,
                                          logic [63:0] entry, logic rf);
        mode_t       m;
        int          n;
        int          l;
        int          d;
        logic [63:0] v;
        logic [63:0] e;
        logic [51:0] base;
        logic [51:0] frame;
        result_t     r;

        m = !cfg_paging ? MODE_NONE : !cfg_pae ? MODE_32 : cfg_lme ? MODE_LONG4 : MODE_PAE;
        n = (m == MODE_32) ? 2 : (m == MODE_PAE) ? 3 : 4;
        r = '0;
        r.read_bytes = (m == MODE_32) ? 4'd4 : 4'd8;

        if (act == ACT_TRANSLATE)
        begin
            tr_va    = va;
            tr_level = 2'd0;
            if (m == MODE_NONE)
            begin
                tr_busy            = 1'b0;
                r.kind             = KIND_DONE;
                r.physical_address = va[51:0];
                return r;
            end
            v = (m == MODE_LONG4) ? va : {32'h0, va[31:0]};
            base = (m == MODE_32)  ? (cfg_dir & DIR_MASK_32)  :
                   (m == MODE_PAE) ? (cfg_dir & DIR_MASK_PAE) : (cfg_dir & DIR_MASK_LONG);
            tr_busy        = 1'b1;
            r.kind         = KIND_READ;
            r.read_address = base + table_index(m, v, n - 1);
            return r;
        end

        r.kind = KIND_DONE;
        if (!tr_busy || m == MODE_NONE)
        begin
            tr_busy       = 1'b0;
            r.status      = STAT_UNEXPECTED;
            r.fault_level = tr_level;
            return r;
        end

        l = tr_level;
        if (l > n - 1)
            l = n - 1;
        d = n - 1 - l;
        r.fault_level = 2'(l);
        v = (m == MODE_LONG4) ? tr_va : {32'h0, tr_va[31:0]};
        e = (m == MODE_32) ? {32'h0, entry[31:0]} : entry;
        tr_busy = 1'b0;

        if (rf)
        begin
            r.status = STAT_READ_FAILED;
            return r;
        end
        if (!e[0])
        begin
            r.status = STAT_NOT_PRESENT;
            return r;
        end

        frame = (m == MODE_32) ? {20'h0, e[31:12], 12'h0} : {e[51:12], 12'h0};
        if (d == 0)
        begin
            r.physical_address = frame | {40'h0, v[11:0]};
            return r;
        end
        if (d == 1 && e[7])
        begin
            if (m == MODE_32)
            begin
                r.physical_address = {12'h0, e[20:13], e[31:22], v[21:0]};
                r.page_size        = PS_4M;
            end
            else
            begin
                r.physical_address = {frame[51:21], v[20:0]};
                r.page_size        = PS_2M;
            end
            return r;
        end
        if (d == 2 && m == MODE_LONG4 && e[7])
        begin
            r.physical_address = {frame[51:30], v[29:0]};
            r.page_size        = PS_1G;
            return r;
        end

        tr_busy        = 1'b1;
        tr_level       = 2'(l + 1);
        r.kind         = KIND_READ;
        r.read_address = frame + table_index(m, v, d - 1);
        r.fault_level  = tr_level;
        return r;
    endfunction

    task automatic send_request(action_t act, logic [63:0] va, logic [63:0] entry,
                                logic rf, logic typed, result_t known);
        int      gap;
        result_t want;
        gap = idle_length();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        want = walk_step(act, va, entry, rf);
        pending_results.push_back(typed ? known : want);
        in_valid        <= 1'b1;
        action          <= act;
        virtual_address <= va;
        table_entry     <= entry;
        read_failed     <= rf;
        do
            @(posedge clk);
        while (in_stall);
        requests_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_PAGING: cfg_paging = value[0];
            REG_PAE:    cfg_pae    = value[0];
            REG_LME:    cfg_lme    = value[0];
            REG_DIR:    cfg_dir    = value[51:0];
            default:    ;
        endcase
    endtask

    task automatic apply_config(logic pg, logic pae, logic lme, logic [51:0] dir);
        drain_results();
        write_reg(REG_PAGING, {$urandom(), 31'($urandom()), pg});
        write_reg(REG_PAE,    {$urandom(), 31'($urandom()), pae});
        write_reg(REG_LME,    {$urandom(), 31'($urandom()), lme});
        write_reg(REG_DIR,    {12'($urandom()), dir});
        settings_used++;
    endtask

    task automatic check_result(result_t want, result_t got);
        if (got.kind !== want.kind)
        begin
            $error("result_kind: expected %0d, got %0d", want.kind, got.kind);
            mismatches++;
        end
        if (got.read_address !== want.read_address)
        begin
            $error("read_address: expected %h, got %h", want.read_address, got.read_address);
            mismatches++;
        end
        if (got.read_bytes !== want.read_bytes)
        begin
            $error("read_bytes: expected %0d, got %0d", want.read_bytes, got.read_bytes);
            mismatches++;
        end
        if (got.physical_address !== want.physical_address)
        begin
            $error("physical_address: expected %h, got %h",
                   want.physical_address, got.physical_address);
            mismatches++;
        end
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
        end
        if (got.fault_level !== want.fault_level)
        begin
            $error("fault_level: expected %0d, got %0d", want.fault_level, got.fault_level);
            mismatches++;
        end
        if (got.page_size !== want.page_size)
        begin
            $error("page_size: expected %0d, got %0d", want.page_size, got.page_size);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.kind             = kind_t'(result_kind);
            got.read_address     = read_address;
            got.read_bytes       = read_bytes;
            got.physical_address = physical_address;
            got.status           = status_t'(status);
            got.fault_level      = fault_level;
            got.page_size        = page_size_t'(page_size);
            if (pending_results.size() == 0)
            begin
                $error("Result with no request outstanding: kind %0d, status %0d",
                       got.kind, got.status);
                mismatches++;
            end
            else
            begin
                check_result(pending_results.pop_front(), got);
            end
            if (got.kind == KIND_READ)
                reads_seen++;
            else if (got.status == STAT_OK)
                pages_seen++;
            else
                faults_seen++;
        end
    end

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall  <= 1'b0;
            stall_left = rst_n ? idle_length() : 0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timed out with %0d results outstanding.", pending_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        directed_row_t row;
        mode_t         applied_mode;
        logic [51:0]   applied_dir;
        action_t       act;
        logic [63:0]   va;
        logic [63:0]   entry;
        logic          rf;
        logic [2:0]    bits;
        logic [51:0]   dir;

        applied_mode = MODE_NONE;
        applied_dir  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_COUNT; i++)
        begin
            row = DIRECTED_ROWS[i];
            if (row.mode != applied_mode || row.dir != applied_dir)
            begin
                apply_config(row.mode != MODE_NONE,
                             row.mode == MODE_PAE || row.mode == MODE_LONG4,
                             row.mode == MODE_LONG4, row.dir);
                applied_mode = row.mode;
                applied_dir  = row.dir;
            end
            send_request(row.act, row.va, row.entry, row.rf, row.typed, row.known);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            quiet = (p % 5 == 2);
            if (p < 8)
                bits = 3'(p);
            else
                bits = {1'b1, 1'($urandom()), 1'($urandom())};
            dir = (p % 4 == 1) ? 52'h0 : (p % 4 == 3) ? ONES52 :
                  {20'($urandom()), 32'($urandom())};
            apply_config(bits[2], bits[1], bits[0], dir);
            for (int k = 0; k < PHASE_REQUESTS; k++)
            begin
                if (tr_busy)
                    act = ($urandom_range(99) < 90) ? ACT_ENTRY : ACT_TRANSLATE;
                else
                    act = ($urandom_range(99) < 90) ? ACT_TRANSLATE : ACT_ENTRY;
                case ($urandom_range(9))
                    0:       va = 64'h0;
                    1:       va = ONES64;
                    default: va = {$urandom(), $urandom()};
                endcase
                entry    = {$urandom(), $urandom()};
                entry[0] = ($urandom_range(99) < 92);
                entry[7] = ($urandom_range(99) < 30);
                rf       = ($urandom_range(99) < 4);
                send_request(act, va, entry, rf, 1'b0, NO_CHECK);
            end
        end
        quiet = 1'b0;

        drain_results();
        $display("Sent %0d requests under %0d register settings.",
                 requests_sent, settings_used);
        $display("Saw %0d entry reads, %0d translations and %0d faults.",
                 reads_seen, pages_seen, faults_seen);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: files.f
sv/ptw_pkg.sv
sv/x86_page_table_walker.sv
bench/x86_page_table_walker_test.sv
